/* design/pce_pkg.sv */
package pce_pkg;

  localparam int unsigned SYMBOL_W = 8;
  localparam int unsigned CENTER_W = 6;
  localparam int unsigned BOUND_W  = 6;

endpackage

/* design/palindrome_center_enumerator.sv */
// Symbols are taken one per cycle while loading; the final symbol starts the pass.
// The radius pass over the 2N-1 interleaved positions steps over a separator directly in the
// read state, and reads and then compares for each symbol compare or radius mirror check.
// Emission reads each center's radius and then registers its result (EM_RD, then EM_OUT);
// the input stalls from the final symbol until the last result is registered.
// Reset (async, active low) clears the sequencer, symbol count, overflow flag and outputs.
module palindrome_center_enumerator #(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pce_pkg::SYMBOL_W-1:0]  in_symbol_i,
  input  logic                          in_final_symbol_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pce_pkg::CENTER_W-1:0]  out_center_o,
  output logic [pce_pkg::BOUND_W-1:0]   out_left_bound_o,
  output logic [pce_pkg::BOUND_W-1:0]   out_right_bound_o,
  output logic                          out_overflow_o,
  output logic                          out_end_of_run_o
);

  localparam int unsigned RAW  = $clog2(2 * MAX_LEN);
  localparam int unsigned PW   = RAW + 1;
  localparam int unsigned SAW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CNTW = $clog2(MAX_LEN + 1);
  localparam int unsigned RW   = RAW;

  typedef enum logic [2:0] {
    S_LOAD,
    S_EXP_RD,
    S_EXP_CMP,
    S_MIR_RD,
    S_MIR_CMP,
    S_EM_RD,
    S_EM_OUT
  } state_e;

  state_e                        state_q;
  logic [CNTW-1:0]               count_q;
  logic                          ovf_q;
  logic [PW-1:0]                 len_q;
  logic [PW-1:0]                 c_q;
  logic [PW-1:0]                 k_q;
  logic [RW-1:0]                 reach_q;

  logic                          out_valid_q;
  logic [pce_pkg::CENTER_W-1:0]  out_center_q;
  logic [pce_pkg::BOUND_W-1:0]   out_left_q;
  logic [pce_pkg::BOUND_W-1:0]   out_right_q;
  logic                          out_ovf_q;
  logic                          out_end_q;

  // memories
  logic [pce_pkg::SYMBOL_W-1:0]  sym_mem [MAX_LEN];
  logic [RW-1:0]                 rad_mem [2*MAX_LEN];
  logic [pce_pkg::SYMBOL_W-1:0]  sym_a_q, sym_b_q;
  logic [RW-1:0]                 rad_q;

  logic                          in_acc;
  logic                          room;
  logic [CNTW-1:0]               count_new;
  logic [PW-1:0]                 reach_x, lo_pos, hi_pos, step_c, sum_kr;
  logic                          exp_ok, mir_ok, mir_go, exit_done, sym_eq, out_free;
  logic                          out_load;
  logic                          sym_we, sym_re, rad_we, rad_re;
  logic [SAW-1:0]                sym_waddr, sym_raddr_a, sym_raddr_b;
  logic [RAW-1:0]                rad_waddr, rad_raddr;
  logic [RW-1:0]                 rad_wdata;
  logic [PW-1:0]                 mid, half_w, lo_b, hi_b;

  assign in_stall_o = (state_q != S_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign room       = (count_q < CNTW'(MAX_LEN));
  assign count_new  = room ? count_q + 1'b1 : count_q;

  assign reach_x   = PW'(reach_q);
  assign lo_pos    = c_q - reach_x;
  assign hi_pos    = c_q + reach_x;
  assign exp_ok    = (reach_x <= c_q) && (hi_pos < len_q);
  assign mir_ok    = (k_q <= c_q) && ((c_q + k_q) < len_q);
  assign sum_kr    = k_q + PW'(rad_q);
  assign mir_go    = (sum_kr < reach_x);
  assign step_c    = c_q + k_q;
  assign exit_done = (step_c >= len_q);
  assign sym_eq    = (sym_a_q == sym_b_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign out_load  = (state_q == S_EM_OUT) && out_free;

  always_comb begin
    sym_we      = in_acc && room;
    sym_waddr   = SAW'(count_q);
    sym_re      = (state_q == S_EXP_RD) && exp_ok && !lo_pos[0];
    sym_raddr_a = lo_pos[SAW:1];
    sym_raddr_b = hi_pos[SAW:1];
    rad_we      = 1'b0;
    rad_waddr   = c_q[RAW-1:0];
    rad_wdata   = reach_q;
    rad_re      = 1'b0;
    rad_raddr   = c_q[RAW-1:0];
    case (state_q)
      S_EXP_RD: begin
        rad_we = !exp_ok;
      end
      S_EXP_CMP: begin
        rad_we = !sym_eq;
      end
      S_MIR_RD: begin
        rad_re    = mir_ok;
        rad_raddr = RAW'(c_q - k_q);
      end
      S_MIR_CMP: begin
        rad_we    = mir_go;
        rad_waddr = RAW'(step_c);
        rad_wdata = rad_q;
      end
      S_EM_RD: begin
        rad_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (sym_we) begin
      sym_mem[sym_waddr] <= in_symbol_i;
    end
    if (sym_re) begin
      sym_a_q <= sym_mem[sym_raddr_a];
      sym_b_q <= sym_mem[sym_raddr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rad_we) begin
      rad_mem[rad_waddr] <= rad_wdata;
    end
    if (rad_re) begin
      rad_q <= rad_mem[rad_raddr];
    end
  end

  // bounds of the palindrome at the emitted center
  always_comb begin
    mid = (c_q + 1'b1) >> 1;
    if (c_q[0]) begin
      half_w = PW'(rad_q >> 1);
      lo_b   = mid - half_w;
      hi_b   = mid + half_w;
    end else begin
      half_w = PW'((rad_q - 1'b1) >> 1);
      lo_b   = mid - half_w;
      hi_b   = mid + half_w + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      len_q        <= '0;
      c_q          <= '0;
      k_q          <= '0;
      reach_q      <= '0;
      out_valid_q  <= 1'b0;
      out_center_q <= '0;
      out_left_q   <= '0;
      out_right_q  <= '0;
      out_ovf_q    <= 1'b0;
      out_end_q    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            count_q <= count_new;
            if (!room) begin
              ovf_q <= 1'b1;
            end
            if (in_final_symbol_i) begin
              len_q   <= (PW'(count_new) << 1) - 1'b1;
              c_q     <= '0;
              reach_q <= '0;
              state_q <= S_EXP_RD;
            end
          end
        end
        S_EXP_RD: begin
          if (!exp_ok) begin
            k_q     <= PW'(1);
            state_q <= S_MIR_RD;
          end else if (lo_pos[0]) begin
            reach_q <= reach_q + 1'b1;
          end else begin
            state_q <= S_EXP_CMP;
          end
        end
        S_EXP_CMP: begin
          if (sym_eq) begin
            reach_q <= reach_q + 1'b1;
            state_q <= S_EXP_RD;
          end else begin
            k_q     <= PW'(1);
            state_q <= S_MIR_RD;
          end
        end
        S_MIR_RD, S_MIR_CMP: begin
          if (state_q == S_MIR_RD && mir_ok) begin
            state_q <= S_MIR_CMP;
          end else if (state_q == S_MIR_CMP && mir_go) begin
            k_q     <= k_q + 1'b1;
            state_q <= S_MIR_RD;
          end else begin
            reach_q <= RW'(reach_x - k_q);
            if (exit_done) begin
              c_q     <= '0;
              state_q <= S_EM_RD;
            end else begin
              c_q     <= step_c;
              state_q <= S_EXP_RD;
            end
          end
        end
        S_EM_RD: begin
          state_q <= S_EM_OUT;
        end
        S_EM_OUT: begin
          if (out_free) begin
            out_center_q <= pce_pkg::CENTER_W'(c_q);
            out_left_q   <= pce_pkg::BOUND_W'(lo_b);
            out_right_q  <= pce_pkg::BOUND_W'(hi_b);
            out_ovf_q    <= ovf_q;
            out_end_q    <= (c_q == len_q - 1'b1);
            if (c_q == len_q - 1'b1) begin
              count_q <= '0;
              ovf_q   <= 1'b0;
              state_q <= S_LOAD;
            end else begin
              c_q     <= c_q + 1'b1;
              state_q <= S_EM_RD;
            end
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_center_o      = out_center_q;
  assign out_left_bound_o  = out_left_q;
  assign out_right_bound_o = out_right_q;
  assign out_overflow_o    = out_ovf_q;
  assign out_end_of_run_o  = out_end_q;

endmodule

/* design/pce_checker.sv */
module pce_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [pce_pkg::SYMBOL_W-1:0]  in_symbol_i,
  input logic                          in_final_symbol_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [pce_pkg::CENTER_W-1:0]  out_center_o,
  input logic [pce_pkg::BOUND_W-1:0]   out_left_bound_o,
  input logic [pce_pkg::BOUND_W-1:0]   out_right_bound_o,
  input logic                          out_overflow_o,
  input logic                          out_end_of_run_o
);

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_center_o) &&
      $stable(out_left_bound_o) && $stable(out_right_bound_o) &&
      $stable(out_overflow_o) && $stable(out_end_of_run_o))
    else $error("output transaction changed while stalled");

  // no new symbol is taken while a sequence is being processed
  a_final_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_final_symbol_i |=> in_stall_o)
    else $error("input taken after final symbol");

  a_bound_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_right_bound_o >= out_left_bound_o &&
      out_left_bound_o <= out_center_o)
    else $error("bounds out of order");

  // a center on a symbol always covers that symbol
  a_odd_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_center_o[0] |-> out_right_bound_o > out_left_bound_o)
    else $error("empty palindrome at symbol center");

endmodule

bind palindrome_center_enumerator pce_checker u_pce_checker (.*);

/* sim/palindrome_center_enumerator_tb.sv */
module palindrome_center_enumerator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN        = 32;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int PHASE_ITEMS    = 48;
  localparam int TAIL_CYCLES    = 60;

  typedef enum int {
    SEQ_TWO_SYMBOLS,
    SEQ_FULL_RANGE,
    SEQ_MIRRORED
  } seq_kind_e;

  typedef struct packed {
    logic [pce_pkg::SYMBOL_W-1:0] symbol;
    logic                         final_symbol;
  } symbol_txn_t;

  typedef struct packed {
    logic [pce_pkg::CENTER_W-1:0] center;
    logic [pce_pkg::BOUND_W-1:0]  left_bound;
    logic [pce_pkg::BOUND_W-1:0]  right_bound;
    logic                         overflow;
    logic                         end_of_run;
  } span_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [pce_pkg::SYMBOL_W-1:0] in_symbol_i = '0;
  logic                         in_final_symbol_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [pce_pkg::CENTER_W-1:0] out_center_o;
  logic [pce_pkg::BOUND_W-1:0]  out_left_bound_o;
  logic [pce_pkg::BOUND_W-1:0]  out_right_bound_o;
  logic                         out_overflow_o;
  logic                         out_end_of_run_o;

  symbol_txn_t pending_symbols[$];
  span_t       expected_spans[$];

  logic [pce_pkg::SYMBOL_W-1:0] seq_mem[MAX_LEN];
  int                           seq_count = 0;
  bit                           seq_dropped = 1'b0;

  int  queued_items = 0;
  int  mismatches = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  holdoff_asked = 0;
  int  holdoff_seen = 0;
  int  holdoff_left = 0;
  bit  in_taken = 1'b0;

  palindrome_center_enumerator #(
    .MAX_LEN(MAX_LEN)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_symbol_i       (in_symbol_i),
    .in_final_symbol_i (in_final_symbol_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_center_o      (out_center_o),
    .out_left_bound_o  (out_left_bound_o),
    .out_right_bound_o (out_right_bound_o),
    .out_overflow_o    (out_overflow_o),
    .out_end_of_run_o  (out_end_of_run_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // interleaved positions: even = symbol, odd = separator (separators always match)
  function automatic bit positions_equal(int a, int b);
    if (a[0])
      return 1'b1;
    return seq_mem[a >> 1] == seq_mem[b >> 1];
  endfunction

  function automatic void predict_palindromes(symbol_txn_t txn);
    int    n_pos;
    int    radius;
    int    half;
    int    lo;
    int    hi;
    span_t s;
    if (seq_count < MAX_LEN) begin
      seq_mem[seq_count] = txn.symbol;
      seq_count++;
    end else begin
      seq_dropped = 1'b1;
    end
    if (!txn.final_symbol)
      return;
    n_pos = 2 * seq_count - 1;
    for (int c = 0; c < n_pos; c++) begin
      radius = 1;
      while (c - radius >= 0 && c + radius < n_pos && positions_equal(c - radius, c + radius))
        radius++;
      if (c % 2 == 1) begin
        half = radius / 2;
        lo = (c + 1) / 2 - half;
        hi = (c + 1) / 2 + half;
      end else begin
        half = (radius - 1) / 2;
        lo = c / 2 - half;
        hi = c / 2 + half + 1;
      end
      s.center      = c[pce_pkg::CENTER_W-1:0];
      s.left_bound  = lo[pce_pkg::BOUND_W-1:0];
      s.right_bound = hi[pce_pkg::BOUND_W-1:0];
      s.overflow    = seq_dropped;
      s.end_of_run  = (c == n_pos - 1);
      expected_spans.push_back(s);
    end
    seq_count = 0;
    seq_dropped = 1'b0;
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH at %0t: %s", $realtime, msg);
  endfunction

  function automatic void check_span(span_t got);
    span_t want;
    if (expected_spans.size() == 0) begin
      note_mismatch($sformatf("unexpected result center=%0d left=%0d right=%0d",
                              got.center, got.left_bound, got.right_bound));
      return;
    end
    want = expected_spans.pop_front();
    if (got !== want)
      note_mismatch($sformatf(
        "center %0d/%0d left %0d/%0d right %0d/%0d ovf %0b/%0b eor %0b/%0b (exp/act)",
        want.center, got.center, want.left_bound, got.left_bound,
        want.right_bound, got.right_bound, want.overflow, got.overflow,
        want.end_of_run, got.end_of_run));
  endfunction

  function automatic void push_item(logic [pce_pkg::SYMBOL_W-1:0] sym, logic fin);
    symbol_txn_t txn;
    txn.symbol = sym;
    txn.final_symbol = fin;
    pending_symbols.push_back(txn);
    queued_items++;
  endfunction

  function automatic void queue_sequence(int len);
    seq_kind_e                    kind;
    logic [pce_pkg::SYMBOL_W-1:0] sym_a;
    logic [pce_pkg::SYMBOL_W-1:0] sym_b;
    logic [pce_pkg::SYMBOL_W-1:0] seq[$];
    kind  = seq_kind_e'($urandom_range(0, 2));
    sym_a = pce_pkg::SYMBOL_W'($urandom_range(0, 255));
    sym_b = pce_pkg::SYMBOL_W'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      case (kind)
        SEQ_FULL_RANGE: begin
          seq.push_back(pce_pkg::SYMBOL_W'($urandom_range(0, 255)));
        end
        SEQ_MIRRORED: begin
          if (i >= (len + 1) / 2 && $urandom_range(0, 7) != 0)
            seq.push_back(seq[len - 1 - i]);
          else
            seq.push_back($urandom_range(0, 1) ? sym_a : sym_b);
        end
        default: begin
          seq.push_back($urandom_range(0, 1) ? sym_a : sym_b);
        end
      endcase
    end
    foreach (seq[i])
      push_item(seq[i], i == len - 1);
  endfunction

  function automatic int pick_length();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(MAX_LEN - 2, MAX_LEN + 4);
    return $urandom_range(1, 10);
  endfunction

  task automatic wait_drained();
    do
      @(negedge clk_i);
    while (pending_symbols.size() != 0 || (in_valid_i && !in_taken) ||
           expected_spans.size() != 0);
    @(posedge clk_i);
  endtask

  // driver
  always @(negedge clk_i) begin : drive
    symbol_txn_t txn;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_symbols.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        txn = pending_symbols.pop_front();
        in_valid_i        <= 1'b1;
        in_symbol_i       <= txn.symbol;
        in_final_symbol_i <= txn.final_symbol;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (holdoff_seen != holdoff_asked) begin
      holdoff_seen = holdoff_asked;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i)
        check_span('{center: out_center_o, left_bound: out_left_bound_o,
                     right_bound: out_right_bound_o, overflow: out_overflow_o,
                     end_of_run: out_end_of_run_o});
      if (in_valid_i && !in_stall_o)
        predict_palindromes('{symbol: in_symbol_i, final_symbol: in_final_symbol_i});
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int phase_start;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // single symbols at both extremes
    push_item(8'h00, 1'b1);
    push_item(8'hFF, 1'b1);
    // odd palindrome, even palindrome, no match, nested even run
    push_item(8'hA5, 1'b0);
    push_item(8'h5A, 1'b0);
    push_item(8'hA5, 1'b1);
    push_item(8'h80, 1'b0);
    push_item(8'h01, 1'b0);
    push_item(8'h01, 1'b0);
    push_item(8'h80, 1'b1);
    push_item(8'h12, 1'b0);
    push_item(8'h34, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b1);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      phase_start = queued_items;
      if (p == 0)
        queue_sequence(MAX_LEN);
      if (p == 2)
        queue_sequence(MAX_LEN + 2);
      while (queued_items - phase_start < PHASE_ITEMS)
        queue_sequence(pick_length());
      // long output hold-off while symbols keep coming
      if (p == 0)
        holdoff_asked++;
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

/* palindrome_center_enumerator.f */
design/pce_pkg.sv
design/palindrome_center_enumerator.sv
design/pce_checker.sv
sim/palindrome_center_enumerator_tb.sv
